[hw/rtl/asc_pkg.sv]
`default_nettype none
package asc_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned IDX_W      = 7;
  localparam int unsigned KEY_W      = 16;
  localparam int unsigned LEN_REG_W  = 8;
  localparam int unsigned ADDR_W     = 4;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned DEFAULT_LEN = 62;

  localparam logic [DEFAULT_LEN*BYTE_W-1:0] DEFAULT_ALPHA =
      "AaBbCcDdEeFfGgHhIiJjKkLlMmNnOoPpQqRrSsTtUuVvWwXxYyZz0123456789";

  // input kinds carried on tuser
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_CIPHER = 1'b1;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_KEY  = 2'd0;
  localparam logic [1:0] REG_MODE = 2'd1;
  localparam logic [1:0] REG_LEN  = 2'd2;

  // reset content of table entry j: first character sits in the top byte of the string
  function automatic logic [BYTE_W-1:0] default_char(input int j);
    logic [BYTE_W-1:0] c;
    c = '0;
    if (j < DEFAULT_LEN) begin
      c = DEFAULT_ALPHA[(DEFAULT_LEN - 1 - j) * BYTE_W +: BYTE_W];
    end
    return c;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/alphabet_shift_cipher_unit.sv]
// channel   dir  tdata (low bit first)            tuser
// s_axis    in   entry_index[6:0] byte_value[14:7] action (0 load, 1 cipher)
// m_axis    out  out_byte[7:0]                     found
// apb       cfg  0x0 shift_key, 0x4 decode_mode, 0x8 alphabet_length
//
// A load beat writes its byte into the indexed cell. A cipher beat walks the cell ring
// once to find the byte and, if found, once more to pick the shifted entry; the next
// beat is taken only after that result has moved to the output register. After a
// write to shift_key or alphabet_length, s_axis_tready stays low while the key is
// reduced one bit per cycle. Reset restores the default alphabet; a held result
// stalls the next result, and no new beat is taken while that one waits.
`default_nettype none
module alphabet_shift_cipher_unit #(
  parameter int unsigned ALPHA_MAX = 128
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output      logic                          s_axis_tready,
  input  wire logic [15:0]                   s_axis_tdata,  // entry_index, byte_value
  input  wire logic                          s_axis_tuser,  // action
  output      logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output      logic [7:0]                    m_axis_tdata,  // out_byte
  output      logic                          m_axis_tuser,  // found
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [asc_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [asc_pkg::DATA_W-1:0]    pwdata,
  output      logic [asc_pkg::DATA_W-1:0]    prdata,
  output      logic                          pready
);

  localparam int unsigned IW = $clog2(ALPHA_MAX);
  localparam int unsigned LW = $clog2(ALPHA_MAX + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FETCH,
    ST_EMIT
  } state_e;

  state_e                        state_q;
  logic [IW-1:0]                 cnt_q;
  logic [asc_pkg::BYTE_W-1:0]    byte_q;
  logic [asc_pkg::BYTE_W-1:0]    res_q;
  logic                          found_q;
  logic [IW-1:0]                 idx_q;
  logic                          m_valid_q;
  logic [asc_pkg::BYTE_W-1:0]    m_data_q;
  logic                          m_user_q;

  logic [asc_pkg::KEY_W-1:0]     key_q;
  logic                          mode_q;
  logic [asc_pkg::LEN_REG_W-1:0] len_q;

  logic                          cfg_we;
  logic [1:0]                    reg_idx;
  logic [LW-1:0]                 len_eff;
  logic [asc_pkg::KEY_W-1:0]     key_next;
  logic [asc_pkg::LEN_REG_W-1:0] len_next;
  logic [LW-1:0]                 len_eff_next;
  logic                          div_busy;
  logic [LW-1:0]                 key_mod;
  logic                          in_fire;
  logic                          load_we;
  logic [asc_pkg::BYTE_W-1:0]    head;
  logic                          hit;
  logic                          last_step;
  logic [LW:0]                   pos;
  logic [LW:0]                   idx_w;
  logic [LW:0]                   sum_w;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q  <= '0;
      mode_q <= 1'b0;
      len_q  <= asc_pkg::LEN_REG_W'(asc_pkg::DEFAULT_LEN);
    end else if (cfg_we) begin
      case (reg_idx)
        asc_pkg::REG_KEY:  key_q  <= pwdata[asc_pkg::KEY_W-1:0];
        asc_pkg::REG_MODE: mode_q <= pwdata[0];
        asc_pkg::REG_LEN:  len_q  <= pwdata[asc_pkg::LEN_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      asc_pkg::REG_KEY:  prdata = asc_pkg::DATA_W'(key_q);
      asc_pkg::REG_MODE: prdata = asc_pkg::DATA_W'(mode_q);
      asc_pkg::REG_LEN:  prdata = asc_pkg::DATA_W'(len_q);
      default:           prdata = '0;
    endcase
  end

  assign len_eff = (int'(len_q) > ALPHA_MAX) ? LW'(ALPHA_MAX) : LW'(len_q);

  // the divider starts on the write edge, so hand it the values being written
  always_comb begin
    key_next = key_q;
    len_next = len_q;
    if (reg_idx == asc_pkg::REG_KEY) begin
      key_next = pwdata[asc_pkg::KEY_W-1:0];
    end
    if (reg_idx == asc_pkg::REG_LEN) begin
      len_next = pwdata[asc_pkg::LEN_REG_W-1:0];
    end
  end

  assign len_eff_next = (int'(len_next) > ALPHA_MAX) ? LW'(ALPHA_MAX) : LW'(len_next);

  asc_keymod #(
    .LW (LW)
  ) u_keymod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cfg_we && (reg_idx == asc_pkg::REG_KEY || reg_idx == asc_pkg::REG_LEN)),
    .key_i     (key_next),
    .len_i     (len_eff_next),
    .busy_o    (div_busy),
    .key_mod_o (key_mod)
  );

  // cell ring
  assign s_axis_tready = (state_q == ST_IDLE) && !div_busy;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign load_we       = in_fire && (s_axis_tuser == asc_pkg::ACT_LOAD);

  asc_ring #(
    .N (ALPHA_MAX)
  ) u_ring (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .shift_en_i  (state_q == ST_SEARCH || state_q == ST_FETCH),
    .load_we_i   (load_we),
    .load_idx_i  (s_axis_tdata[asc_pkg::IDX_W-1:0]),
    .load_data_i (s_axis_tdata[asc_pkg::IDX_W +: asc_pkg::BYTE_W]),
    .head_o      (head)
  );

  assign hit       = !found_q && (LW'(cnt_q) < len_eff) && (head == byte_q);
  assign last_step = (cnt_q == IW'(ALPHA_MAX - 1));

  // target position of the shifted entry
  always_comb begin
    idx_w = (LW+1)'(idx_q);
    sum_w = idx_w + (LW+1)'(key_mod);
    if (mode_q) begin
      if (idx_w >= (LW+1)'(key_mod)) begin
        pos = idx_w - (LW+1)'(key_mod);
      end else begin
        pos = idx_w + (LW+1)'(len_eff) - (LW+1)'(key_mod);
      end
    end else begin
      if (sum_w >= (LW+1)'(len_eff)) begin
        pos = sum_w - (LW+1)'(len_eff);
      end else begin
        pos = sum_w;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      byte_q    <= '0;
      res_q     <= '0;
      found_q   <= 1'b0;
      idx_q     <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      m_user_q  <= 1'b0;
    end else begin
      if (state_q == ST_EMIT && (!m_valid_q || m_axis_tready)) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire && s_axis_tuser == asc_pkg::ACT_CIPHER) begin
            byte_q  <= s_axis_tdata[asc_pkg::IDX_W +: asc_pkg::BYTE_W];
            found_q <= 1'b0;
            cnt_q   <= '0;
            state_q <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (hit) begin
            found_q <= 1'b1;
            idx_q   <= cnt_q;
          end
          if (last_step) begin
            cnt_q   <= '0;
            res_q   <= byte_q;
            state_q <= (found_q || hit) ? ST_FETCH : ST_EMIT;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_FETCH: begin
          if ((LW+1)'(cnt_q) == pos) begin
            res_q <= head;
          end
          if (last_step) begin
            cnt_q   <= '0;
            state_q <= ST_EMIT;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_EMIT: begin
          // hold until the output slot frees up
          if (!m_valid_q || m_axis_tready) begin
            m_data_q  <= res_q;
            m_user_q  <= found_q;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule
`default_nettype wire

[hw/rtl/asc_cell.sv]
`default_nettype none
module asc_cell #(
  parameter logic [7:0] INIT = 8'h00
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       shift_en_i,
  input  wire logic [7:0] shift_in_i,
  input  wire logic       load_en_i,
  input  wire logic [7:0] load_data_i,
  output      logic [7:0] entry_o
);

  logic [7:0] entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= INIT;
    end else if (load_en_i) begin
      entry_q <= load_data_i;
    end else if (shift_en_i) begin
      entry_q <= shift_in_i;
    end
  end

  assign entry_o = entry_q;

endmodule
`default_nettype wire

[hw/rtl/asc_ring.sv]
`default_nettype none
module asc_ring #(
  parameter int unsigned N = 128
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        shift_en_i,
  input  wire logic                        load_we_i,
  input  wire logic [asc_pkg::IDX_W-1:0]   load_idx_i,
  input  wire logic [asc_pkg::BYTE_W-1:0]  load_data_i,
  output      logic [asc_pkg::BYTE_W-1:0]  head_o
);

  logic [asc_pkg::BYTE_W-1:0] entry [N];

  // each cell takes its upper neighbor, so after c steps the head shows entry c
  for (genvar j = 0; j < N; j++) begin : g_cell
    asc_cell #(
      .INIT (asc_pkg::default_char(j))
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .shift_en_i  (shift_en_i),
      .shift_in_i  (entry[(j + 1) % N]),
      .load_en_i   (load_we_i && (int'(load_idx_i) == j)),
      .load_data_i (load_data_i),
      .entry_o     (entry[j])
    );
  end

  assign head_o = entry[0];

endmodule
`default_nettype wire

[hw/rtl/asc_keymod.sv]
`default_nettype none
module asc_keymod #(
  parameter int unsigned LW = 8
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [asc_pkg::KEY_W-1:0]  key_i,
  input  wire logic [LW-1:0]              len_i,
  output      logic                       busy_o,
  output      logic [LW-1:0]              key_mod_o
);

  localparam int unsigned CW = $clog2(asc_pkg::KEY_W);

  logic                      busy_q;
  logic [CW-1:0]             cnt_q;
  logic [asc_pkg::KEY_W-1:0] key_q;
  logic [LW-1:0]             rem_q;
  logic [LW:0]               trial;
  logic [LW-1:0]             rem_d;

  // restoring remainder, one key bit per cycle from the top
  always_comb begin
    trial = {rem_q, key_q[asc_pkg::KEY_W-1]};
    if (trial >= {1'b0, len_i}) begin
      rem_d = LW'(trial - {1'b0, len_i});
    end else begin
      rem_d = LW'(trial);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      key_q  <= '0;
      rem_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
      key_q  <= key_i;
      rem_q  <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      key_q <= {key_q[asc_pkg::KEY_W-2:0], 1'b0};
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CW'(asc_pkg::KEY_W - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign busy_o    = busy_q;
  assign key_mod_o = rem_q;

endmodule
`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

  localparam int ALPHA_MAX      = 128;
  // a cipher beat walks the ring twice; leave room for the key reduction after a write
  localparam int DRAIN_CYCLES   = 2 * ALPHA_MAX + 40;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS   = 1730;
  localparam logic [1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic       action;
    logic [6:0] idx;
    logic [7:0] sym;
  } sym_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       found;
  } cipher_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // entry_index[6:0], byte_value[14:7], zero pad[15]
  logic        s_axis_tuser = 1'b0; // action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // out_byte[7:0]
  logic        m_axis_tuser;        // found
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [asc_pkg::ADDR_W-1:0] paddr = '0;
  logic [asc_pkg::DATA_W-1:0] pwdata = '0;
  logic [asc_pkg::DATA_W-1:0] prdata;
  logic        pready;

  // predictor state
  logic [7:0]  alpha_tbl [ALPHA_MAX];
  logic [15:0] key_reg;
  logic        mode_reg;
  logic [7:0]  len_reg;
  string       reset_alphabet =
      "AaBbCcDdEeFfGgHhIiJjKkLlMmNnOoPpQqRrSsTtUuVvWwXxYyZz0123456789";

  sym_beat_t   sym_queue [$];
  cipher_res_t cipher_out_q [$];

  sym_beat_t   drv_beat = '0;
  logic        drv_busy = 1'b0;
  logic        in_taken = 1'b0;
  int          send_gap = 0;
  int          sink_hold = 0;
  logic        jitter_on = 1'b0;
  int          err_count = 0;
  int          quiet_cycles = 0;

  alphabet_shift_cipher_unit #(
    .ALPHA_MAX(ALPHA_MAX)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $time, what);
    err_count++;
  endtask

  function automatic cipher_res_t shift_lookup(input logic [7:0] sym);
    cipher_res_t res;
    int n;
    int hit;
    int k;
    int pos;
    int j;
    res.out_byte = sym;
    res.found    = 1'b0;
    n   = (int'(len_reg) > ALPHA_MAX) ? ALPHA_MAX : int'(len_reg);
    hit = -1;
    // scan downward so the lowest matching entry wins
    for (j = n - 1; j >= 0; j--) begin
      if (alpha_tbl[j] == sym) hit = j;
    end
    if (hit >= 0) begin
      k   = int'(key_reg) % n;
      pos = mode_reg ? (hit + n - k) % n : (hit + k) % n;
      res.out_byte = alpha_tbl[pos];
      res.found    = 1'b1;
    end
    return res;
  endfunction

  function automatic logic [31:0] cfg_value(input logic [1:0] reg_idx);
    case (reg_idx)
      asc_pkg::REG_KEY:  return {16'h0, key_reg};
      asc_pkg::REG_MODE: return {31'h0, mode_reg};
      default:           return {24'h0, len_reg};
    endcase
  endfunction

  // sample both streams, predict on input beats, check output beats
  always @(posedge clk_i) begin
    cipher_res_t exp_res;
    in_taken = rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (cipher_out_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte %02h found %0b",
                                  m_axis_tdata, m_axis_tuser));
      end else begin
        exp_res = cipher_out_q.pop_front();
        if (m_axis_tdata !== exp_res.out_byte)
          report_mismatch($sformatf("out_byte %02h, expected %02h",
                                    m_axis_tdata, exp_res.out_byte));
        if (m_axis_tuser !== exp_res.found)
          report_mismatch($sformatf("found %0b, expected %0b",
                                    m_axis_tuser, exp_res.found));
      end
    end
    if (in_taken) begin
      if (s_axis_tuser == asc_pkg::ACT_LOAD)
        alpha_tbl[s_axis_tdata[6:0]] = s_axis_tdata[14:7];
      else
        cipher_out_q.push_back(shift_lookup(s_axis_tdata[14:7]));
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // input driver: present queued beats, hold until taken
  always @(negedge clk_i) begin
    if (in_taken) begin
      drv_busy = 1'b0;
      if (jitter_on && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 10);
    end
    if (!drv_busy) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (sym_queue.size() > 0) begin
        drv_beat = sym_queue.pop_front();
        drv_busy = 1'b1;
      end
    end
    s_axis_tvalid <= drv_busy;
    s_axis_tdata  <= {1'b0, drv_beat.sym, drv_beat.idx};
    s_axis_tuser  <= drv_beat.action;
  end

  // output sink: random backpressure bursts
  always @(negedge clk_i) begin
    if (sink_hold > 0) begin
      sink_hold--;
      m_axis_tready <= 1'b0;
    end else if (jitter_on && $urandom_range(0, 5) == 0) begin
      sink_hold = $urandom_range(1, 10) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic push_beat(input logic act, input logic [6:0] idx, input logic [7:0] sym);
    sym_beat_t b;
    b.action = act;
    b.idx    = idx;
    b.sym    = sym;
    sym_queue.push_back(b);
  endtask

  // write a register, then read it back unless it is the spare one; ends on a rising edge
  task automatic cfg_write(input logic [1:0] reg_idx, input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (reg_idx)
      asc_pkg::REG_KEY:  key_reg  = value[asc_pkg::KEY_W-1:0];
      asc_pkg::REG_MODE: mode_reg = value[0];
      asc_pkg::REG_LEN:  len_reg  = value[asc_pkg::LEN_REG_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    if (reg_idx == REG_SPARE) begin
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
    end else begin
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clk_i);
      penable <= 1'b1;
      @(posedge clk_i);
      if (prdata !== cfg_value(reg_idx))
        report_mismatch($sformatf("register %0d reads %08h, expected %08h",
                                  reg_idx, prdata, cfg_value(reg_idx)));
      @(negedge clk_i);
      psel    <= 1'b0;
      penable <= 1'b0;
    end
    @(posedge clk_i);
  endtask

  // wait until every beat is taken and every result is back, then let the block go quiet
  task automatic settle();
    while (sym_queue.size() != 0 || drv_busy || cipher_out_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic queue_random_phase(input int count);
    logic [7:0] shadow [ALPHA_MAX];
    sym_beat_t  b;
    int eff;
    int j;
    for (j = 0; j < ALPHA_MAX; j++) shadow[j] = alpha_tbl[j];
    eff = (int'(len_reg) > ALPHA_MAX) ? ALPHA_MAX : int'(len_reg);
    repeat (count) begin
      b.idx = 7'($urandom_range(0, ALPHA_MAX - 1));
      b.sym = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 9) < 3) begin
        b.action = asc_pkg::ACT_LOAD;
        if (eff > 0 && $urandom_range(0, 1) == 1) b.idx = 7'($urandom_range(0, eff - 1));
        // copy an existing entry now and then to plant duplicates
        if ($urandom_range(0, 3) == 0) b.sym = shadow[$urandom_range(0, ALPHA_MAX - 1)];
        shadow[b.idx] = b.sym;
      end else begin
        b.action = asc_pkg::ACT_CIPHER;
        if (eff > 0 && $urandom_range(0, 3) != 0) b.sym = shadow[$urandom_range(0, eff - 1)];
      end
      sym_queue.push_back(b);
    end
  endtask

  initial begin
    int issued;
    int count;
    int phase;
    int j;
    int pick;
    logic [15:0] key_pick;
    logic [7:0]  len_pick;

    for (j = 0; j < ALPHA_MAX; j++)
      alpha_tbl[j] = (j < reset_alphabet.len()) ? reset_alphabet[j] : 8'h00;
    key_reg  = '0;
    mode_reg = 1'b0;
    len_reg  = 8'(asc_pkg::DEFAULT_LEN);

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset alphabet and registers: both ends of the table, absent bytes
    jitter_on = 1'b1;
    push_beat(asc_pkg::ACT_CIPHER, 7'd0, "A");
    push_beat(asc_pkg::ACT_CIPHER, 7'd0, "9");
    push_beat(asc_pkg::ACT_CIPHER, 7'd0, "z");
    push_beat(asc_pkg::ACT_CIPHER, 7'd0, 8'h00);
    push_beat(asc_pkg::ACT_CIPHER, 7'd0, 8'hFF);
    settle();

    // largest key, decode, and a write to an unmapped register
    cfg_write(asc_pkg::REG_KEY, 32'h0000_FFFF);
    cfg_write(asc_pkg::REG_MODE, 32'd1);
    cfg_write(REG_SPARE, 32'hFFFF_FFFF);
    push_beat(asc_pkg::ACT_LOAD, 7'd7, "A");
    push_beat(asc_pkg::ACT_CIPHER, 7'd0, "A");
    push_beat(asc_pkg::ACT_CIPHER, 7'd0, "D");
    settle();

    // full table: zero entries repeat, so the lowest one matches
    cfg_write(asc_pkg::REG_LEN, 32'd128);
    cfg_write(asc_pkg::REG_MODE, 32'd0);
    push_beat(asc_pkg::ACT_LOAD, 7'd127, 8'hFF);
    push_beat(asc_pkg::ACT_CIPHER, 7'd0, 8'hFF);
    push_beat(asc_pkg::ACT_CIPHER, 7'd0, 8'h00);
    push_beat(asc_pkg::ACT_CIPHER, 7'd0, 8'h7F);
    settle();

    // length past the table saturates
    cfg_write(asc_pkg::REG_LEN, 32'd200);
    push_beat(asc_pkg::ACT_CIPHER, 7'd0, 8'hFF);
    push_beat(asc_pkg::ACT_CIPHER, 7'd0, "A");
    settle();

    cfg_write(asc_pkg::REG_LEN, 32'd255);
    cfg_write(asc_pkg::REG_KEY, 32'd0);
    push_beat(asc_pkg::ACT_CIPHER, 7'd0, 8'h00);
    push_beat(asc_pkg::ACT_LOAD, 7'd0, 8'hFF);
    push_beat(asc_pkg::ACT_CIPHER, 7'd0, 8'hFF);
    settle();

    // empty alphabet passes everything through
    cfg_write(asc_pkg::REG_LEN, 32'd0);
    push_beat(asc_pkg::ACT_CIPHER, 7'd0, "A");
    push_beat(asc_pkg::ACT_CIPHER, 7'd0, 8'h00);
    settle();

    // single entry: any key maps it to itself
    cfg_write(asc_pkg::REG_LEN, 32'd1);
    cfg_write(asc_pkg::REG_KEY, 32'd12345);
    push_beat(asc_pkg::ACT_CIPHER, 7'd0, 8'hFF);
    push_beat(asc_pkg::ACT_CIPHER, 7'd0, "a");
    settle();

    issued = 0;
    phase  = 0;
    while (issued < RANDOM_ITEMS) begin
      count = $urandom_range(30, 70);
      pick  = $urandom_range(0, 3);
      key_pick = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
      pick  = $urandom_range(0, 15);
      case (pick)
        0:       len_pick = 8'd0;
        1:       len_pick = 8'd255;
        2:       len_pick = 8'd128;
        3:       len_pick = 8'd1;
        4:       len_pick = 8'($urandom_range(129, 254));
        default: len_pick = 8'($urandom_range(2, 127));
      endcase
      cfg_write(asc_pkg::REG_KEY, {16'h0, key_pick});
      cfg_write(asc_pkg::REG_MODE, {31'h0, 1'($urandom_range(0, 1))});
      cfg_write(asc_pkg::REG_LEN, {24'h0, len_pick});
      // quiet stretches now and then, and none at the tail
      jitter_on = (phase % 5 != 3) && (issued + count < RANDOM_ITEMS - 150);
      queue_random_phase(count);
      issued += count;
      phase++;
      settle();
    end

    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
